// ----- rtl/ring_leader_election_node_defines.svh -----
// Assertion macros for the ring leader election node.
`ifndef RING_LEADER_ELECTION_NODE_DEFINES_SVH
`define RING_LEADER_ELECTION_NODE_DEFINES_SVH

// Expression must hold at every clock edge out of reset.
`define RLEN_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RLEN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rlen_pkg.sv -----
// Types and constants shared by the ring leader election node.
package rlen_pkg;

	localparam int ID_BITS    = 6;
	localparam int DIST_BITS  = 8;
	localparam int PHASE_BITS = 3;
	localparam int CMD_BITS   = 2;
	localparam int KIND_BITS  = 2;

	localparam logic [PHASE_BITS-1:0] MAX_PHASE = PHASE_BITS'(7);

	localparam logic [CMD_BITS-1:0] CMD_START = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_OUT   = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_IN    = 2'd2;

	localparam logic [KIND_BITS-1:0] KIND_OUT     = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_IN      = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_ELECTED = 2'd2;

	localparam logic REG_OWN_ID       = 1'b0;
	localparam logic REG_IS_INITIATOR = 1'b1;

	typedef struct packed {
		logic [CMD_BITS-1:0]  cmd;
		logic [ID_BITS-1:0]   probe_id;
		logic [DIST_BITS-1:0] probe_distance;
		logic                 from_right;
	} item_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] out_kind;
		logic                 to_right;
		logic [ID_BITS-1:0]   msg_id;
		logic [DIST_BITS-1:0] msg_distance;
		logic                 last;
	} result_t;

	// One or two results caused by the same item
	typedef struct packed {
		logic    two;
		result_t r1;
		result_t r0;
	} group_t;

endpackage

// ----- rtl/ring_leader_election_node.sv -----
// Ring leader election node: input stage, election logic and result queue.
//
//  channel | dir | handshake          | transaction
//  item    | in  | item_valid/stall   | item_t: cmd, probe id, distance, side
//  result  | out | result_valid/stall | result_t: kind, side, id, distance, last
//  cfg     | in  | cfg_valid/ready    | register index and write data
//
// One item per cycle unless stalled; an item sits in the input register, where
// the compare-and-count logic runs, and its results enter a two-entry queue.
// An item with two results gives them out one after the other, r0 first.
// Reset clears the control state and counters; cfg_ready is always high.
// The input stalls while the input register holds an item and the queue is full.
`include "ring_leader_election_node_defines.svh"

module ring_leader_election_node import rlen_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  item_t               item,
	output logic                result_valid,
	input  logic                result_stall,
	output result_t             result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [ID_BITS-1:0]  cfg_data
);

	logic [ID_BITS-1:0]    own_id_q;
	logic                  is_init_q;
	logic [PHASE_BITS-1:0] phase_q, phase_d;
	logic [1:0]            in_ret_q, in_ret_d, in_inc;
	logic [1:0]            out_ret_q, out_ret_d, out_inc;
	logic                  defeated_q, defeated_d;
	logic                  elected_q, elected_d;

	logic                  valid_s1;
	item_t                 item_s1;
	logic                  s1_fire, accept, do_start;
	logic [1:0]            n_res;
	result_t               res0, res1;
	logic [DIST_BITS-1:0]  start_dist;

	group_t                grp_mem [2];
	logic                  wr_ptr_q, rd_ptr_q, sub_q;
	logic [1:0]            grp_cnt_q;
	logic                  full, push, pop, grp_pop;
	group_t                head;

	assign cfg_ready  = 1'b1;
	assign full       = (grp_cnt_q == 2'd2);
	assign s1_fire    = valid_s1 && !full;
	assign item_stall = valid_s1 && full;
	assign accept     = item_valid && !item_stall;
	assign push       = s1_fire && (n_res != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q  <= '0;
			is_init_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OWN_ID:       own_id_q  <= cfg_data;
				REG_IS_INITIATOR: is_init_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	assign start_dist = DIST_BITS'(1) << phase_q;
	assign in_inc     = (in_ret_q == 2'd3) ? in_ret_q : in_ret_q + 2'd1;
	assign out_inc    = (out_ret_q == 2'd3) ? out_ret_q : out_ret_q + 2'd1;

	always_comb begin
		phase_d    = phase_q;
		in_ret_d   = in_ret_q;
		out_ret_d  = out_ret_q;
		defeated_d = defeated_q;
		elected_d  = elected_q;
		n_res      = 2'd0;
		res0       = '0;
		res1       = '0;
		do_start   = 1'b0;
		case (item_s1.cmd)
			CMD_START: begin
				do_start = is_init_q;
			end
			CMD_OUT: begin
				if (!is_init_q || item_s1.probe_id > own_id_q) begin
					defeated_d = 1'b1;
					n_res      = 2'd1;
					if (item_s1.probe_distance > DIST_BITS'(1)) begin
						res0 = '{KIND_OUT, !item_s1.from_right, item_s1.probe_id,
							item_s1.probe_distance - DIST_BITS'(1), 1'b1};
					end else begin
						res0 = '{KIND_IN, item_s1.from_right, item_s1.probe_id,
							item_s1.probe_distance, 1'b1};
					end
				end else if (item_s1.probe_id == own_id_q) begin
					out_ret_d = out_inc;
					if (out_inc == 2'd2) begin
						elected_d = 1'b1;
						n_res     = 2'd1;
						res0      = '{KIND_ELECTED, 1'b1, own_id_q, '0, 1'b1};
					end
				end
			end
			CMD_IN: begin
				if (item_s1.probe_id != own_id_q) begin
					n_res = 2'd1;
					res0  = '{KIND_IN, !item_s1.from_right, item_s1.probe_id,
						item_s1.probe_distance, 1'b1};
				end else begin
					in_ret_d = in_inc;
					do_start = (in_inc == 2'd2);
				end
			end
			default: ;
		endcase
		if (do_start) begin
			in_ret_d  = '0;
			out_ret_d = '0;
			n_res     = 2'd2;
			res0      = '{KIND_OUT, 1'b1, own_id_q, start_dist, 1'b0};
			res1      = '{KIND_OUT, 1'b0, own_id_q, start_dist, 1'b1};
			if (phase_q != MAX_PHASE) begin
				phase_d = phase_q + PHASE_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			in_ret_q   <= '0;
			out_ret_q  <= '0;
			defeated_q <= 1'b0;
			elected_q  <= 1'b0;
		end else if (s1_fire) begin
			phase_q    <= phase_d;
			in_ret_q   <= in_ret_d;
			out_ret_q  <= out_ret_d;
			defeated_q <= defeated_d;
			elected_q  <= elected_d;
		end
	end

	// result queue, two groups deep
	always_ff @(posedge clk) begin
		if (push) begin
			grp_mem[wr_ptr_q] <= '{(n_res == 2'd2), res1, res0};
		end
	end

	assign head         = grp_mem[rd_ptr_q];
	assign result_valid = (grp_cnt_q != 2'd0);
	assign result       = sub_q ? head.r1 : head.r0;
	assign pop          = result_valid && !result_stall;
	assign grp_pop      = pop && (sub_q || !head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			sub_q     <= 1'b0;
			grp_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (grp_pop) begin
				rd_ptr_q <= !rd_ptr_q;
				sub_q    <= 1'b0;
			end else if (pop) begin
				sub_q <= 1'b1;
			end
			case ({push, grp_pop})
				2'b10:   grp_cnt_q <= grp_cnt_q + 2'd1;
				2'b01:   grp_cnt_q <= grp_cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	`RLEN_ASSERT_ALWAYS(a_queue_bound, grp_cnt_q != 2'd3, "result queue overflow")
	`RLEN_ASSERT_NEXT(a_elected_sticky, elected_q, elected_q, "elected flag dropped")
	`RLEN_ASSERT_NEXT(a_defeated_sticky, defeated_q, defeated_q, "defeated flag dropped")
	`RLEN_ASSERT_ALWAYS(a_elect_count, !out_ret_q[1] || elected_q, "returns counted without election")

endmodule

// ----- tb/sv/ring_leader_election_node_tb.sv -----
// Self-checking testbench for the ring leader election node.
module ring_leader_election_node_tb;
	import rlen_pkg::*;

	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

	localparam int IDLE_PCT       = 38;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ROUNDS         = 24;
	localparam int ROUND_ITEMS    = 64;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	item_t               item = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_index = REG_OWN_ID;
	logic [ID_BITS-1:0]  cfg_data = '0;

	ring_leader_election_node i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// node state as predicted
	logic [ID_BITS-1:0]    cfg_own = '0;
	logic                  cfg_initiator = 1'b0;
	logic [PHASE_BITS-1:0] node_phase = '0;
	logic [1:0]            node_in_returns = '0;
	logic [1:0]            node_out_returns = '0;
	logic                  node_defeated = 1'b0;
	logic                  node_elected = 1'b0;

	result_t pending_msgs[$];

	int errors = 0;
	int items_sent = 0;
	int msgs_checked = 0;
	int reg_writes = 0;
	int elections = 0;
	int phase_starts = 0;

	logic calm = 1'b0;
	int   hold_asks = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   quiet_cycles = 0;

	function automatic result_t build_msg(logic [KIND_BITS-1:0] kind, logic right,
			logic [ID_BITS-1:0] id, logic [DIST_BITS-1:0] hops, logic last);
		result_t m;
		m.out_kind     = kind;
		m.to_right     = right;
		m.msg_id       = id;
		m.msg_distance = hops;
		m.last         = last;
		return m;
	endfunction

	function automatic item_t make_item(logic [CMD_BITS-1:0] cmd, logic [ID_BITS-1:0] id,
			logic [DIST_BITS-1:0] hops, logic fr);
		item_t it;
		it.cmd            = cmd;
		it.probe_id       = id;
		it.probe_distance = hops;
		it.from_right     = fr;
		return it;
	endfunction

	// both probes of a new phase, then the phase doubling
	task automatic launch_probes();
		logic [DIST_BITS-1:0] d;
		d = DIST_BITS'(1);
		d = d << node_phase;
		node_in_returns  = '0;
		node_out_returns = '0;
		pending_msgs.push_back(build_msg(KIND_OUT, 1'b1, cfg_own, d, 1'b0));
		pending_msgs.push_back(build_msg(KIND_OUT, 1'b0, cfg_own, d, 1'b1));
		if (node_phase < MAX_PHASE)
			node_phase = node_phase + 1'b1;
		phase_starts++;
	endtask

	task automatic forecast_messages(item_t it);
		case (it.cmd)
			CMD_START: begin
				if (cfg_initiator)
					launch_probes();
			end
			CMD_OUT: begin
				if (!cfg_initiator || it.probe_id > cfg_own) begin
					node_defeated = 1'b1;
					if (it.probe_distance > 1)
						pending_msgs.push_back(build_msg(KIND_OUT, ~it.from_right,
							it.probe_id, it.probe_distance - 1'b1, 1'b1));
					else
						pending_msgs.push_back(build_msg(KIND_IN, it.from_right,
							it.probe_id, it.probe_distance, 1'b1));
				end else if (it.probe_id == cfg_own) begin
					if (node_out_returns < 3)
						node_out_returns = node_out_returns + 1'b1;
					if (node_out_returns == 2) begin
						node_elected = 1'b1;
						elections++;
						pending_msgs.push_back(build_msg(KIND_ELECTED, 1'b1, cfg_own, '0, 1'b1));
					end
				end
			end
			CMD_IN: begin
				if (it.probe_id != cfg_own) begin
					pending_msgs.push_back(build_msg(KIND_IN, ~it.from_right,
						it.probe_id, it.probe_distance, 1'b1));
				end else begin
					if (node_in_returns < 3)
						node_in_returns = node_in_returns + 1'b1;
					if (node_in_returns == 2)
						launch_probes();
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(item_t it);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		forecast_messages(it);
		items_sent++;
	endtask

	// sender stops and waits until the node has gone quiet
	task automatic settle();
		item_valid <= 1'b0;
		while (pending_msgs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [ID_BITS-1:0] id, logic initiator);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_OWN_ID;
		cfg_data  <= id;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_own = id;
		reg_writes++;
		cfg_index <= REG_IS_INITIATOR;
		cfg_data  <= {{(ID_BITS-1){1'b0}}, initiator};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_initiator = initiator;
		reg_writes++;
		cfg_valid <= 1'b0;
	endtask

	function automatic item_t random_item();
		item_t it;
		int    sel;
		sel = $urandom_range(99);
		if (sel < 15)
			it.cmd = CMD_START;
		else if (sel < 55)
			it.cmd = CMD_OUT;
		else if (sel < 95)
			it.cmd = CMD_IN;
		else
			it.cmd = CMD_UNUSED;
		sel = $urandom_range(99);
		if (sel < 35)
			it.probe_id = cfg_own;
		else if (sel < 45)
			it.probe_id = cfg_own + 1'b1;
		else if (sel < 55)
			it.probe_id = cfg_own - 1'b1;
		else
			it.probe_id = ID_BITS'($urandom);
		sel = $urandom_range(99);
		if (sel < 10)
			it.probe_distance = 8'd0;
		else if (sel < 20)
			it.probe_distance = 8'd1;
		else if (sel < 25)
			it.probe_distance = 8'd2;
		else if (sel < 32)
			it.probe_distance = 8'd128;
		else if (sel < 37)
			it.probe_distance = DIST_BITS'($urandom);
		else
			it.probe_distance = DIST_BITS'($urandom_range(128));
		it.from_right = 1'($urandom_range(1));
		return it;
	endfunction

	// own probes coming home in a plausible order, with relay traffic in between
	task automatic run_election_trace();
		send_item(make_item(CMD_START, cfg_own, 8'd0, 1'($urandom_range(1))));
		repeat ($urandom_range(3)) begin
			repeat ($urandom_range(2)) send_item(random_item());
			send_item(make_item(CMD_IN, cfg_own, DIST_BITS'($urandom_range(128)), 1'b1));
			repeat ($urandom_range(2)) send_item(random_item());
			send_item(make_item(CMD_IN, cfg_own, DIST_BITS'($urandom_range(128)), 1'b0));
		end
		send_item(make_item(CMD_OUT, cfg_own, DIST_BITS'($urandom_range(128)), 1'b0));
		repeat ($urandom_range(2)) send_item(random_item());
		send_item(make_item(CMD_OUT, cfg_own, DIST_BITS'($urandom_range(128)), 1'b1));
	endtask

	task automatic test_passive_node();
		set_config(6'd21, 1'b0);
		send_item(make_item(CMD_START, 6'd21, 8'd0, 1'b0));
		send_item(make_item(CMD_OUT, 6'd63, 8'd128, 1'b1));
		send_item(make_item(CMD_OUT, 6'd0, 8'd1, 1'b0));
		send_item(make_item(CMD_OUT, 6'd21, 8'd0, 1'b1));
		send_item(make_item(CMD_IN, 6'd40, 8'd255, 1'b0));
		send_item(make_item(CMD_UNUSED, 6'd63, 8'd255, 1'b1));
		send_item(make_item(CMD_IN, 6'd21, 8'd4, 1'b1));
		send_item(make_item(CMD_IN, 6'd21, 8'd4, 1'b0));
	endtask

	task automatic test_initiator_node();
		set_config(6'd32, 1'b1);
		// phase climbs to its ceiling and stays there
		repeat (8) send_item(make_item(CMD_START, 6'd0, 8'd0, 1'b0));
		send_item(make_item(CMD_OUT, 6'd31, 8'd5, 1'b1));
		send_item(make_item(CMD_OUT, 6'd33, 8'd2, 1'b0));
		repeat (3) send_item(make_item(CMD_OUT, 6'd32, 8'd128, 1'b1));
		send_item(make_item(CMD_IN, 6'd32, 8'd1, 1'b1));
		send_item(make_item(CMD_IN, 6'd32, 8'd1, 1'b0));
	endtask

	task automatic test_backpressure();
		set_config(6'($urandom), 1'b1);
		calm      <= 1'b1;
		hold_asks <= hold_asks + 1;
		repeat (40) send_item(random_item());
		settle();
		calm <= 1'b0;
	endtask

	task automatic test_random_rounds();
		logic [ID_BITS-1:0] id;
		logic               initiator;
		for (int r = 0; r < ROUNDS; r++) begin
			case (r % 4)
				0: id = '0;
				1: id = '1;
				default: id = ID_BITS'($urandom);
			endcase
			initiator = (r % 3 == 2) ? 1'b0 : 1'($urandom_range(1));
			if (r < 2)
				initiator = 1'b1;
			set_config(id, initiator);
			calm <= (r >= 8 && r < 11);
			for (int n = 0; n < ROUND_ITEMS; ) begin
				if ($urandom_range(99) < 20) begin
					run_election_trace();
					n += 10;
				end else begin
					send_item(random_item());
					n++;
				end
			end
		end
		calm <= 1'b0;
	endtask

	// result side: checks against the oldest expectation, then picks the next stall
	always @(posedge clk) begin : rx_side
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_msgs.size() == 0) begin
				$error("result with nothing expected: %p", result);
				errors++;
			end else begin
				want = pending_msgs.pop_front();
				msgs_checked++;
				if (result.out_kind !== want.out_kind) begin
					$error("out_kind: expected %0d, got %0d", want.out_kind, result.out_kind);
					errors++;
				end
				if (result.to_right !== want.to_right) begin
					$error("to_right: expected %0d, got %0d", want.to_right, result.to_right);
					errors++;
				end
				if (result.msg_id !== want.msg_id) begin
					$error("msg_id: expected %0d, got %0d", want.msg_id, result.msg_id);
					errors++;
				end
				if (result.msg_distance !== want.msg_distance) begin
					$error("msg_distance: expected %0d, got %0d",
						want.msg_distance, result.msg_distance);
					errors++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					errors++;
				end
			end
		end
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no transaction for %0d cycles, %0d results outstanding",
				quiet_cycles, pending_msgs.size());
			$display("ring_leader_election_node_tb failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_passive_node();
		test_initiator_node();
		test_backpressure();
		test_random_rounds();
		settle();
		$display("%0d items, %0d results checked, %0d register writes",
			items_sent, msgs_checked, reg_writes);
		$display("%0d phase starts, %0d elections, final phase %0d, %0d mismatches",
			phase_starts, elections, node_phase, errors);
		if (errors == 0)
			$display("ring_leader_election_node_tb passed");
		else
			$display("ring_leader_election_node_tb failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rlen_pkg.sv
rtl/ring_leader_election_node.sv
tb/sv/ring_leader_election_node_tb.sv
